// File: hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types, defaults and codes for the text console cell store.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // default screen geometry
    localparam int DEF_SCREEN_COLS = 80;
    localparam int DEF_SCREEN_ROWS = 25;

    // character and attribute codes
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    localparam int CELL_W = 16;

    // command codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  char_code;
        logic [10:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_word;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_COPY,
        ST_FILL,
        ST_RESULT
    } t_state;

endpackage : tcw_pkg
`default_nettype wire

// File: hw/rtl/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : tcw_ram
`default_nettype wire

// File: hw/rtl/text_console_writer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer unit
// Cell store of SCREEN_ROWS x SCREEN_COLS 16-bit cells with a write cursor.
// Input (i_in_valid / o_in_stall / i_in_data): one word per command. A put
//   writes a character at the cursor (newline moves to the next row), a read
//   fetches one cell by index. Each word gives one result word on the output
//   (o_out_valid / i_out_stall / o_out_data) with the cursor after the command.
// Config (i_cfg_valid / o_cfg_ready / i_cfg_data): attribute byte for new
//   characters and for the blank bottom row; always ready.
// Sequence: a put or an out-of-range read goes from IDLE to RESULT; a read
//   passes RD_WAIT in between (registered RAM read). A scrolling put copies
//   the screen up one cell a cycle (COPY) and blanks the bottom row (FILL).
//   Input is stalled while a command is in progress.
// Reset: the store is swept to grey-on-black spaces, one cell a cycle;
//   input stays stalled.
// Back-pressure: a finished result waits in the output register while
//   i_out_stall is high; the next command starts once it has been loaded.
// ----------------------------------------------------------------------------
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // command input
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    // result output
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data,
    // colour register write
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    // geometry derived widths
    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNW   = $clog2(CELLS + 1);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CW    = $clog2(SCREEN_COLS);
    localparam int RW1   = RW + 1;
    localparam int CW1   = CW + 1;

    localparam logic [CNW-1:0] CELLS_C    = CNW'(CELLS);
    localparam logic [CNW-1:0] LAST_C     = CNW'(CELLS - 1);
    localparam logic [CNW-1:0] COLS_CNT   = CNW'(SCREEN_COLS);
    localparam logic [AW-1:0]  COLS_ADDR  = AW'(SCREEN_COLS);
    localparam logic [AW-1:0]  LAST_BASE  = AW'((SCREEN_ROWS - 1) * SCREEN_COLS);
    localparam logic [CW1-1:0] COLS_V     = CW1'(SCREEN_COLS);
    localparam logic [RW1-1:0] ROWS_V     = RW1'(SCREEN_ROWS);
    localparam logic [RW-1:0]  LAST_ROW   = RW'(SCREEN_ROWS - 1);

    // sequencer state
    t_state          r_state,    n_state;
    logic [RW-1:0]   r_row,      n_row;
    logic [CW-1:0]   r_col,      n_col;
    logic [AW-1:0]   r_row_base, n_row_base;   // r_row * SCREEN_COLS
    logic [7:0]      r_color;
    logic [CNW-1:0]  r_src,      n_src;        // scroll copy read pointer
    logic [CNW-1:0]  r_dst,      n_dst;        // write pointer: clear, copy, fill
    logic            r_wr_act,   n_wr_act;     // copy read data pending
    t_out_item       r_res,      n_res;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out;

    // RAM ports
    logic               ram_we;
    logic [AW-1:0]      ram_wa;
    logic [CELL_W-1:0]  ram_wd;
    logic               ram_re;
    logic [AW-1:0]      ram_ra;
    logic [CELL_W-1:0]  ram_rd;

    logic out_load;

    tcw_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (CELLS)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_row_base  <= '0;
            r_src       <= '0;
            r_dst       <= '0;
            r_wr_act    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_row_base  <= n_row_base;
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_wr_act    <= n_wr_act;
            r_out_valid <= n_out_valid;
        end
    end

    // colour register; ready at all times
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= RESET_COLOR;
        end else if (i_cfg_valid) begin
            r_color <= i_cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    // next state, cursor update and RAM control
    always_comb begin
        logic [CW1-1:0] col_inc;
        logic [RW1-1:0] row_nxt;
        logic [CW-1:0]  col_nxt;
        logic           row_adv;
        logic           do_scroll;
        logic           is_nl;

        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_row_base  = r_row_base;
        n_src       = r_src;
        n_dst       = r_dst;
        n_wr_act    = r_wr_act;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_wa      = r_dst[AW-1:0];
        ram_wd      = {r_color, SPACE_CODE};
        ram_re      = 1'b0;
        ram_ra      = r_src[AW-1:0];
        out_load    = 1'b0;
        o_in_stall  = 1'b1;

        // cursor advance for a put
        is_nl   = (i_in_data.char_code == NEWLINE_CODE);
        col_inc = CW1'(r_col) + CW1'(1);
        if (is_nl || col_inc == COLS_V) begin
            col_nxt = '0;
            row_adv = 1'b1;
        end else begin
            col_nxt = col_inc[CW-1:0];
            row_adv = 1'b0;
        end
        row_nxt   = RW1'(r_row) + RW1'(row_adv);
        do_scroll = (row_nxt == ROWS_V);

        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                ram_wd = {RESET_COLOR, SPACE_CODE};
                if (r_dst == LAST_C) begin
                    n_dst   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_dst = r_dst + CNW'(1);
                end
            end

            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_res.cell_word  = '0;
                    n_res.cursor_row = 5'(r_row);
                    n_res.cursor_col = 7'(r_col);
                    n_res.scrolled   = 1'b0;
                    if (i_in_data.cmd == CMD_READ) begin
                        if (32'(i_in_data.read_index) < CELLS) begin
                            ram_re  = 1'b1;
                            ram_ra  = AW'(i_in_data.read_index);
                            n_state = ST_RD_WAIT;
                        end else begin
                            n_state = ST_RESULT;
                        end
                    end else begin
                        if (!is_nl) begin
                            ram_we = 1'b1;
                            ram_wa = r_row_base + AW'(r_col);
                            ram_wd = {r_color, i_in_data.char_code};
                        end
                        n_col = col_nxt;
                        n_res.cursor_col = 7'(col_nxt);
                        if (do_scroll) begin
                            n_row            = LAST_ROW;
                            n_row_base       = LAST_BASE;
                            n_src            = COLS_CNT;
                            n_dst            = '0;
                            n_wr_act         = 1'b0;
                            n_res.cursor_row = 5'(LAST_ROW);
                            n_res.scrolled   = 1'b1;
                            n_state          = ST_COPY;
                        end else begin
                            n_row            = row_nxt[RW-1:0];
                            n_res.cursor_row = 5'(row_nxt[RW-1:0]);
                            if (row_adv) begin
                                n_row_base = r_row_base + COLS_ADDR;
                            end
                            n_state = ST_RESULT;
                        end
                    end
                end
            end

            ST_RD_WAIT: begin
                n_res.cell_word = ram_rd;
                n_state         = ST_RESULT;
            end

            // read one row below, write the cell read in the previous cycle
            ST_COPY: begin
                if (r_src != CELLS_C) begin
                    ram_re = 1'b1;
                    n_src  = r_src + CNW'(1);
                end
                n_wr_act = (r_src != CELLS_C);
                if (r_wr_act) begin
                    ram_we = 1'b1;
                    ram_wd = ram_rd;
                    n_dst  = r_dst + CNW'(1);
                end
                if (r_src == CELLS_C) begin
                    n_state = ST_FILL;
                end
            end

            // blank the bottom row in the current colour
            ST_FILL: begin
                ram_we = 1'b1;
                if (r_dst == LAST_C) begin
                    n_state = ST_RESULT;
                end else begin
                    n_dst = r_dst + CNW'(1);
                end
            end

            ST_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
    // cursor never leaves the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < SCREEN_ROWS) && (32'(r_col) < SCREEN_COLS))
        else $error("cursor outside screen");

    // copy writes trail reads by exactly one row plus one cell
    a_copy_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY && r_wr_act) |-> (32'(r_src) == 32'(r_dst) + SCREEN_COLS + 1))
        else $error("scroll copy pointers out of step");

    // no RAM write beyond the last cell
    a_wr_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (32'(ram_wa) < CELLS))
        else $error("cell write out of range");

    // a scrolling put leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && r_res.scrolled) |-> (r_row == LAST_ROW))
        else $error("scroll left cursor off bottom row");

    // a new result only appears out of the result state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_RESULT))
        else $error("result word from wrong state");
`endif

endmodule : text_console_writer_unit
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends put and read commands to the console cell store and checks every
// result word against a cycle-free model of the screen, the cursor and the
// colour register held in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
    import tcw_pkg::*;

    localparam int COLS  = DEF_SCREEN_COLS;
    localparam int ROWS  = DEF_SCREEN_ROWS;
    localparam int CELLS = COLS * ROWS;

    // Screen model plus the queue of result words still owed by the block.
    class screen_scoreboard;
        logic [15:0] cells [0:CELLS-1];
        int unsigned row;
        int unsigned col;
        logic [7:0]  colour;
        t_out_item   results_due [$];
        int          errors;

        function new();
            for (int i = 0; i < CELLS; i++) cells[i] = {RESET_COLOR, SPACE_CODE};
            row    = 0;
            col    = 0;
            colour = RESET_COLOR;
            errors = 0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch %0d: %s", errors, msg);
        endtask

        // Work out the result of one accepted command word.
        function void apply_command(input t_in_item w);
            t_out_item r;
            r = '0;
            if (w.cmd == CMD_READ) begin
                if (w.read_index < CELLS) r.cell_word = cells[w.read_index];
            end else begin
                if (w.char_code == NEWLINE_CODE) begin
                    row++;
                    col = 0;
                end else begin
                    cells[row * COLS + col] = {colour, w.char_code};
                    col++;
                end
                if (col >= COLS) begin
                    col = 0;
                    row++;
                end
                if (row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = {colour, SPACE_CODE};
                    row        = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            r.cursor_row = row[4:0];
            r.cursor_col = col[6:0];
            results_due.push_back(r);
        endfunction

        task compare_result(input t_out_item got);
            t_out_item want;
            if (results_due.size() == 0) begin
                report($sformatf("result word %h with nothing expected", got));
                return;
            end
            want = results_due.pop_front();
            if (got.cell_word !== want.cell_word)
                report($sformatf("cell_word %h, want %h", got.cell_word, want.cell_word));
            if (got.cursor_row !== want.cursor_row)
                report($sformatf("cursor_row %0d, want %0d", got.cursor_row, want.cursor_row));
            if (got.cursor_col !== want.cursor_col)
                report($sformatf("cursor_col %0d, want %0d", got.cursor_col, want.cursor_col));
            if (got.scrolled !== want.scrolled)
                report($sformatf("scrolled %b, want %b", got.scrolled, want.scrolled));
        endtask
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in_data   = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data  = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       o_cfg_ready;

    // no idling on either side while set
    logic       calm = 1'b0;

    screen_scoreboard sb;

    text_console_writer_unit #(
        .SCREEN_COLS(COLS),
        .SCREEN_ROWS(ROWS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Offer one command word, with random idle cycles ahead of it, and hold it
    // until the block takes it. Valid stays high into the next word when no
    // idle cycle is drawn.
    task automatic send_word(input logic cmd, input logic [7:0] ch,
                             input logic [10:0] idx);
        t_in_item w;
        w.cmd        = cmd;
        w.char_code  = ch;
        w.read_index = idx;
        while (!calm && $urandom_range(0, 99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        sb.apply_command(w);
    endtask

    // Stop offering and wait until every owed result word has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Colour register write; only called with the block idle.
    task automatic write_colour(input logic [7:0] c);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= c;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        i_cfg_valid <= 1'b0;
        sb.colour = c;
    endtask

    // Random read: half the time anywhere (out of range included), otherwise
    // in the cursor row, where fresh characters and scrolled rows sit.
    task automatic send_random_read();
        logic [10:0] idx;
        if ($urandom_range(0, 1) == 0)
            idx = 11'($urandom_range(0, 2047));
        else
            idx = 11'(sb.row * COLS + $urandom_range(0, COLS - 1));
        send_word(CMD_READ, 8'($urandom), idx);
    endtask

    // One text line: a run of characters with reads mixed in, then a newline.
    // Mostly short lines so the cursor reaches the bottom and scrolls often;
    // some long enough to wrap at the right edge.
    task automatic send_line(inout int count);
        int          len;
        logic [7:0]  ch;
        if ($urandom_range(0, 99) < 70)
            len = $urandom_range(0, 12);
        else
            len = $urandom_range(0, 100);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 35) begin
                send_random_read();
                count++;
            end
            ch = 8'($urandom);
            if (ch == NEWLINE_CODE) ch = SPACE_CODE;
            send_word(CMD_PUT, ch, 11'($urandom));
            count++;
        end
        send_word(CMD_PUT, NEWLINE_CODE, 11'($urandom));
        count++;
    endtask

    // Result side: takes words, draws random stall, and once holds off for a
    // long stretch so the block backs up and stalls its input.
    initial begin : result_side
        int results_taken;
        int hold_left;
        results_taken = 0;
        hold_left     = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                sb.compare_result(o_out_data);
                results_taken++;
                if (results_taken == 250) hold_left = 800;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < 38);
            end
        end
    end

    initial begin : run_limit
        #64000000;
        $display("testbench failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] phase_colour [0:4];
        int         count;
        sb = new();
        phase_colour[0] = 8'h1E;
        phase_colour[1] = 8'hFF;
        phase_colour[2] = 8'h00;
        phase_colour[3] = 8'($urandom);
        phase_colour[4] = RESET_COLOR;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: cleared store, both ends of the index range, reads past
        // the end, control and extreme bytes, newline, then colour changes.
        send_word(CMD_READ, 8'hFF, 11'd0);
        send_word(CMD_READ, 8'h00, 11'd1999);
        send_word(CMD_READ, 8'h00, 11'd2000);
        send_word(CMD_READ, 8'hFF, 11'd2047);
        send_word(CMD_PUT, 8'h41, 11'd2047);
        send_word(CMD_PUT, 8'h00, 11'd0);
        send_word(CMD_PUT, 8'hFF, 11'd0);
        send_word(CMD_PUT, 8'h0D, 11'd0);
        send_word(CMD_PUT, NEWLINE_CODE, 11'd0);
        for (int i = 0; i < 4; i++) send_word(CMD_READ, 8'h00, 11'(i));
        drain_results();
        write_colour(8'h00);
        send_word(CMD_PUT, 8'h78, 11'd0);
        send_word(CMD_PUT, 8'h7F, 11'd0);
        drain_results();
        write_colour(8'hFF);
        send_word(CMD_PUT, 8'h79, 11'd0);
        send_word(CMD_PUT, NEWLINE_CODE, 11'd0);
        // earlier cells keep their old attribute
        for (int i = 80; i < 84; i++) send_word(CMD_READ, 8'h00, 11'(i));

        // Random phases, each with its own colour; the middle one runs with
        // no idling on either side.
        for (int p = 0; p < 5; p++) begin
            drain_results();
            write_colour(phase_colour[p]);
            calm  = (p == 2);
            count = 0;
            while (count < 340) begin
                if ($urandom_range(0, 99) < 10) begin
                    // noise: any command, any byte, any index
                    send_word(1'($urandom), 8'($urandom), 11'($urandom));
                    count++;
                end else begin
                    send_line(count);
                end
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
